/* sv/i2cbm_pkg.sv */
// Shared types and constants for the I2C bit-level master.
`timescale 1ns / 1ps
`default_nettype none
package i2cbm_pkg;

   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   localparam logic [4:0]  STEP_DONE         = 5'd31;
   localparam logic [3:0]  BYTE_BITS         = 4'd8;
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd50;
   localparam int          QUEUE_DEPTH       = 2;

   typedef struct packed {
      logic       is_cmd;
      op_type     op;
      logic [7:0] wdata;
      logic       send_nak;
      logic       sda_in;
   } item_type;

endpackage
`default_nettype wire

/* sv/i2cbm_front.sv */
// Front end: accepts request transactions and classifies the command code.
`timescale 1ns / 1ps
`default_nettype none
module i2cbm_front (
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_cmd,
   input  wire logic [7:0]         req_wdata,
   input  wire logic               req_send_nak,
   input  wire logic               req_sda_in,
   input  wire logic               queue_full,
   output logic                    push,
   output i2cbm_pkg::item_type     push_item
);

   always_comb begin
      push_item.wdata    = req_wdata;
      push_item.send_nak = req_send_nak;
      push_item.sda_in   = req_sda_in;
      unique case (req_cmd)
         i2cbm_pkg::OP_START: begin
            push_item.is_cmd = 1'b1;
            push_item.op     = i2cbm_pkg::OP_START;
         end
         i2cbm_pkg::OP_STOP: begin
            push_item.is_cmd = 1'b1;
            push_item.op     = i2cbm_pkg::OP_STOP;
         end
         i2cbm_pkg::OP_WRITE: begin
            push_item.is_cmd = 1'b1;
            push_item.op     = i2cbm_pkg::OP_WRITE;
         end
         i2cbm_pkg::OP_READ: begin
            push_item.is_cmd = 1'b1;
            push_item.op     = i2cbm_pkg::OP_READ;
         end
         default: begin
            push_item.is_cmd = 1'b0;
            push_item.op     = i2cbm_pkg::OP_IDLE;
         end
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

endmodule
`default_nettype wire

/* sv/i2cbm_queue.sv */
// Short FIFO of classified transactions between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module i2cbm_queue #(
   parameter int DEPTH = i2cbm_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire i2cbm_pkg::item_type push_item,
   input  wire logic                pop,
   output logic                     full,
   output logic                     not_empty,
   output i2cbm_pkg::item_type      head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   i2cbm_pkg::item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

/* sv/i2cbm_back.sv */
// Back end: bus sequencer, phase timer, shift register and result register.
`timescale 1ns / 1ps
`default_nettype none
module i2cbm_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [15:0]         csr_wdata,
   input  wire logic                item_valid,
   input  wire i2cbm_pkg::item_type item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_scl_level,
   output logic                     rsp_sda_level,
   output logic                     rsp_sda_release,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [7:0]               rsp_rdata,
   output logic                     rsp_ack_bit,
   output logic                     rsp_rejected
);

   typedef struct packed {
      logic rel;
      logic sda;
      logic scl;
   } lines_type;

   function automatic lines_type mk(input logic scl, input logic sda, input logic rel);
      lines_type l;
      l.scl = scl;
      l.sda = sda;
      l.rel = rel;
      return l;
   endfunction

   function automatic lines_type line_levels(input i2cbm_pkg::op_type op,
                                             input logic [4:0] s, input logic b,
                                             input logic nak, input lines_type held);
      lines_type l;
      l = held;
      unique case (op)
         i2cbm_pkg::OP_START: begin
            priority if (s == 5'd0) l = mk(1'b1, 1'b1, 1'b0);
            else if (s == 5'd1)     l = mk(1'b1, 1'b0, 1'b0);
            else                    l = mk(1'b0, 1'b0, 1'b0);
         end
         i2cbm_pkg::OP_STOP: begin
            priority if (s == 5'd0) l = mk(1'b1, 1'b0, 1'b0);
            else if (s == 5'd1)     l = mk(1'b1, 1'b1, 1'b0);
            else                    l = mk(1'b0, 1'b1, 1'b0);
         end
         i2cbm_pkg::OP_WRITE: begin
            priority if (s == 5'd0)          l = mk(1'b0, b, 1'b0);
            else if (s == 5'd1)              l = mk(1'b1, b, 1'b0);
            else if (s == 5'd2)              l = mk(1'b0, b, 1'b0);
            else if (s == 5'd3 || s == 5'd4) l = mk(1'b1, 1'b1, 1'b1);
            else                             l = mk(1'b0, 1'b1, 1'b0);
         end
         i2cbm_pkg::OP_READ: begin
            priority if (s == 5'd0) l = mk(1'b1, 1'b1, 1'b1);
            else if (s == 5'd1)     l = mk(1'b0, 1'b1, 1'b1);
            else if (s == 5'd2)     l = mk(1'b1, nak, 1'b0);
            else if (s == 5'd3)     l = mk(1'b0, nak, 1'b0);
            else                    l = mk(1'b0, 1'b1, 1'b0);
         end
         default: l = held;
      endcase
      return l;
   endfunction

   i2cbm_pkg::op_type op_ff, op_in, op_cur;
   logic [4:0]  step_ff, step_in, step_cur, step_next;
   logic [15:0] tick_ff, tick_in, tick_cur, tick_inc;
   logic [3:0]  bit_ff, bit_in, bit_cur, bit_inc;
   logic [7:0]  shift_ff, shift_in, shift_cur;
   logic        nak_ff, nak_in, nak_cur;
   lines_type   line_ff, line_in, lines;
   logic [7:0]  rdata_ff, rdata_in;
   logic        ack_ff, ack_in;
   logic [15:0] phase_ff;
   logic [15:0] limit;
   logic        advance;
   logic        rej, done, busy;

   logic        rsp_valid_ff, rsp_valid_in;
   lines_type   rsp_lines_ff;
   logic        rsp_busy_ff, rsp_done_ff, rsp_rej_ff;

   assign advance = ~rsp_valid_ff | ~rsp_stall;
   assign pop     = item_valid & advance;
   assign limit   = (phase_ff == '0) ? 16'd1 : phase_ff;

   always_comb begin
      op_cur    = op_ff;
      step_cur  = step_ff;
      tick_cur  = tick_ff;
      bit_cur   = bit_ff;
      shift_cur = shift_ff;
      nak_cur   = nak_ff;
      rej       = 1'b0;
      if (item.is_cmd) begin
         if (op_ff != i2cbm_pkg::OP_IDLE) begin
            rej = 1'b1;
         end else begin
            op_cur    = item.op;
            step_cur  = '0;
            tick_cur  = '0;
            bit_cur   = '0;
            shift_cur = item.wdata;
            nak_cur   = item.send_nak;
         end
      end
      lines    = line_levels(op_cur, step_cur, shift_cur[7], nak_cur, line_ff);
      busy     = (op_cur != i2cbm_pkg::OP_IDLE);
      tick_inc = tick_cur + 16'd1;
      bit_inc  = bit_cur + 4'd1;

      op_in     = op_cur;
      step_in   = step_cur;
      tick_in   = tick_cur;
      bit_in    = bit_cur;
      shift_in  = shift_cur;
      nak_in    = nak_cur;
      line_in   = line_ff;
      rdata_in  = rdata_ff;
      ack_in    = ack_ff;
      done      = 1'b0;
      step_next = i2cbm_pkg::STEP_DONE;

      if (busy) begin
         if (step_cur == i2cbm_pkg::STEP_DONE) begin
            done    = 1'b1;
            line_in = lines;
            op_in   = i2cbm_pkg::OP_IDLE;
            step_in = '0;
            tick_in = '0;
            bit_in  = '0;
         end else if (tick_inc >= limit) begin
            unique case (op_cur)
               i2cbm_pkg::OP_START: begin
                  step_next = (step_cur == 5'd0) ? 5'd1 : i2cbm_pkg::STEP_DONE;
               end
               i2cbm_pkg::OP_STOP: begin
                  step_next = (step_cur < 5'd2) ? step_cur + 5'd1 : i2cbm_pkg::STEP_DONE;
               end
               i2cbm_pkg::OP_WRITE: begin
                  priority if (step_cur <= 5'd1) begin
                     step_next = step_cur + 5'd1;
                  end else if (step_cur == 5'd2) begin
                     shift_in  = {shift_cur[6:0], 1'b0};
                     bit_in    = bit_inc;
                     step_next = (bit_inc >= i2cbm_pkg::BYTE_BITS) ? 5'd3 : 5'd0;
                  end else if (step_cur == 5'd3) begin
                     ack_in    = item.sda_in;
                     step_next = 5'd4;
                  end else begin
                     step_next = i2cbm_pkg::STEP_DONE;
                  end
               end
               i2cbm_pkg::OP_READ: begin
                  priority if (step_cur == 5'd0) begin
                     shift_in  = {shift_cur[6:0], item.sda_in};
                     step_next = 5'd1;
                  end else if (step_cur == 5'd1) begin
                     bit_in = bit_inc;
                     if (bit_inc >= i2cbm_pkg::BYTE_BITS) begin
                        rdata_in  = shift_cur;
                        step_next = 5'd2;
                     end else begin
                        step_next = 5'd0;
                     end
                  end else if (step_cur == 5'd2 || step_cur == 5'd3) begin
                     step_next = step_cur + 5'd1;
                  end else begin
                     step_next = i2cbm_pkg::STEP_DONE;
                  end
               end
               default: step_next = i2cbm_pkg::STEP_DONE;
            endcase
            step_in = step_next;
            tick_in = '0;
         end else begin
            tick_in = tick_inc;
         end
      end

      rsp_valid_in = pop ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= i2cbm_pkg::OP_IDLE;
         step_ff      <= '0;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         nak_ff       <= 1'b0;
         line_ff      <= mk(1'b1, 1'b1, 1'b0);
         rdata_ff     <= '0;
         ack_ff       <= 1'b0;
         phase_ff     <= i2cbm_pkg::PHASE_TICKS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            op_ff    <= op_in;
            step_ff  <= step_in;
            tick_ff  <= tick_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            nak_ff   <= nak_in;
            line_ff  <= line_in;
            rdata_ff <= rdata_in;
            ack_ff   <= ack_in;
         end
         if (csr_we) begin
            phase_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_lines_ff <= lines;
         rsp_busy_ff  <= busy;
         rsp_done_ff  <= done;
         rsp_rej_ff   <= rej;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_level   = rsp_lines_ff.scl;
   assign rsp_sda_level   = rsp_lines_ff.sda;
   assign rsp_sda_release = rsp_lines_ff.rel;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_rdata       = rdata_ff;
   assign rsp_ack_bit     = ack_ff;
   assign rsp_rejected    = rsp_rej_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_done_ff || rsp_rej_ff)) |-> rsp_busy_ff)
      else $error("done or rejected response without busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_lines_ff.rel) |-> rsp_lines_ff.sda)
      else $error("released SDA must report high level");

   assert property (@(posedge clock) disable iff (reset)
      (op_ff == i2cbm_pkg::OP_IDLE) |-> (step_ff == '0 && tick_ff == '0 && bit_ff == '0))
      else $error("idle sequencer holds stale step, tick or bit count");

   assert property (@(posedge clock) disable iff (reset)
      (pop && done) |=> (op_ff == i2cbm_pkg::OP_IDLE))
      else $error("sequencer not idle after done transaction");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         (rsp_valid_ff && $stable(rsp_lines_ff) && $stable(rdata_ff) && $stable(ack_ff)))
      else $error("response register overwritten while stalled");

endmodule
`default_nettype wire

/* sv/i2c_bit_level_master.sv */
// Top level of the I2C bit-level master: front end, transaction queue, back end.
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  cmd, wdata, send_nak, sda_in
//  rsp_     out        rsp_valid/rsp_stall  scl/sda levels, release, busy, done, rdata, ack, rejected
//  csr_     in         csr_we               phase_ticks (16 bit)
//
// One request transaction per cycle sustained while rsp_stall and req_stall stay low; its response
// passes the queue write, then the sequencer step into the response register.
// Each request yields exactly one response; bus phases last phase_ticks requests.
// Reset is synchronous: sequencer idle, SCL and SDA driven high, phase_ticks 50.
// A stalled response holds the sequencer; the queue absorbs up to QUEUE_DEPTH requests,
// then req_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module i2c_bit_level_master #(
   parameter int QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [7:0]  req_wdata,
   input  wire logic        req_send_nak,
   input  wire logic        req_sda_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_level,
   output logic             rsp_sda_level,
   output logic             rsp_sda_release,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_rdata,
   output logic             rsp_ack_bit,
   output logic             rsp_rejected
);

   logic                queue_full;
   logic                queue_not_empty;
   logic                push;
   logic                pop;
   i2cbm_pkg::item_type push_item;
   i2cbm_pkg::item_type head;

   i2cbm_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_wdata    (req_wdata),
      .req_send_nak (req_send_nak),
      .req_sda_in   (req_sda_in),
      .queue_full   (queue_full),
      .push         (push),
      .push_item    (push_item)
   );

   i2cbm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   i2cbm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .item_valid      (queue_not_empty),
      .item            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_sda_release (rsp_sda_release),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_rdata       (rsp_rdata),
      .rsp_ack_bit     (rsp_ack_bit),
      .rsp_rejected    (rsp_rejected)
   );

endmodule
`default_nettype wire
